>>> hw/rtl/spls_pkg.sv
// ---------------------------------------------------------------------------
// Secret pattern line scanner: shared package
// Types, pattern tables and byte codes used by the scanner modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spls_pkg;

    localparam int unsigned NUM_PAT   = 11;
    localparam int unsigned MAX_LEN   = 11;
    localparam int unsigned LINE_BITS = 20;

    typedef logic [7:0]           t_byte;
    typedef logic [MAX_LEN-1:0]   t_prog;
    typedef logic [LINE_BITS-1:0] t_line;
    typedef logic [3:0]           t_pat_idx;

    typedef enum logic {
        KIND_WARN   = 1'b0,
        KIND_BINARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_byte data_byte;
        logic  first_of_file;
        logic  last_of_file;
    } t_item;

    // Contents of the input register as seen by the scan stage.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    localparam t_byte BYTE_LF    = 8'h0A;
    localparam t_byte BYTE_CR    = 8'h0D;
    localparam t_byte BYTE_TAB   = 8'h09;
    localparam t_byte BYTE_EQ    = 8'h3D;
    localparam t_byte BYTE_DQ    = 8'h22;
    localparam t_byte BYTE_SQ    = 8'h27;
    localparam t_byte CTRL_LIMIT = 8'h20;
    localparam t_byte PAD        = 8'h00;

    localparam t_byte PAT_TEXT [NUM_PAT][MAX_LEN] = '{
        '{"A", "P", "I", "_", "K", "E", "Y", PAD, PAD, PAD, PAD},
        '{"S", "E", "C", "R", "E", "T", PAD, PAD, PAD, PAD, PAD},
        '{"T", "O", "K", "E", "N", PAD, PAD, PAD, PAD, PAD, PAD},
        '{"P", "A", "S", "S", PAD, PAD, PAD, PAD, PAD, PAD, PAD},
        '{"A", "U", "T", "H", PAD, PAD, PAD, PAD, PAD, PAD, PAD},
        '{"A", "C", "C", "E", "S", "S", "_", "K", "E", "Y", PAD},
        '{"P", "R", "I", "V", "A", "T", "E", "_", "K", "E", "Y"},
        '{"A", "K", "I", "A", PAD, PAD, PAD, PAD, PAD, PAD, PAD},
        '{"A", "I", "z", "a", PAD, PAD, PAD, PAD, PAD, PAD, PAD},
        '{"g", "h", "p", "_", PAD, PAD, PAD, PAD, PAD, PAD, PAD},
        '{"s", "k", "-", PAD, PAD, PAD, PAD, PAD, PAD, PAD, PAD}
    };

    localparam t_pat_idx PAT_LEN [NUM_PAT] = '{
        4'd7, 4'd6, 4'd5, 4'd4, 4'd4, 4'd10, 4'd11, 4'd4, 4'd4, 4'd4, 4'd3
    };

    // Positions of one pattern at which the byte fits.
    function automatic t_prog pat_mask(input t_pat_idx p, input t_byte b);
        t_prog m;
        m = '0;
        for (int i = 0; i < MAX_LEN; i++) begin
            if ((t_pat_idx'(i) < PAT_LEN[p]) && (PAT_TEXT[p][i] == b)) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/spls_if.sv
// ---------------------------------------------------------------------------
// Secret pattern line scanner: channel interfaces
// Byte request channel and report channel, each with valid and ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface spls_byte_if;
    logic                 valid;
    logic                 ready;
    spls_pkg::t_byte      data_byte;
    logic                 first_of_file;
    logic                 last_of_file;

    modport source (output valid, output data_byte, output first_of_file,
                    output last_of_file, input ready);
    modport sink   (input valid, input data_byte, input first_of_file,
                    input last_of_file, output ready);
endinterface

interface spls_rep_if;
    logic                 valid;
    logic                 ready;
    spls_pkg::t_line      line_num;
    logic                 report_kind;

    modport source (output valid, output line_num, output report_kind, input ready);
    modport sink   (input valid, input line_num, input report_kind, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spls_in_reg.sv
// ---------------------------------------------------------------------------
// Secret pattern line scanner: input register
// Holds one byte request until the scan stage takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module spls_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    spls_byte_if.sink           i_byte,
    input  wire logic           i_advance,
    output spls_pkg::t_stage    o_stage
);

    logic            r_valid;
    logic            n_valid;
    spls_pkg::t_item r_item;
    logic            accept;

    assign i_byte.ready = !r_valid || i_advance;
    assign accept       = i_byte.valid && i_byte.ready;
    assign n_valid      = accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte     <= i_byte.data_byte;
            r_item.first_of_file <= i_byte.first_of_file;
            r_item.last_of_file  <= i_byte.last_of_file;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

`default_nettype wire

>>> hw/rtl/spls_scan.sv
// ---------------------------------------------------------------------------
// Secret pattern line scanner: scan stage
// Shift-and matching, line flags, line counter and the report register.
// ---------------------------------------------------------------------------
`default_nettype none

module spls_scan #(
    parameter int unsigned LINE_COUNT_BITS = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire spls_pkg::t_stage i_stage,
    output logic                  o_advance,
    spls_rep_if.source            o_report
);

    localparam logic [LINE_COUNT_BITS-1:0] COUNT_ONE =
        {{(LINE_COUNT_BITS-1){1'b0}}, 1'b1};

    spls_pkg::t_prog              r_prog [spls_pkg::NUM_PAT];
    spls_pkg::t_prog              n_prog [spls_pkg::NUM_PAT];
    logic                         r_hit, n_hit;
    logic                         r_eq, n_eq;
    logic                         r_quote, n_quote;
    logic                         r_bin, n_bin;
    logic                         r_skip, n_skip;
    logic [LINE_COUNT_BITS-1:0]   r_count, n_count;

    logic                         r_out_valid, n_out_valid;
    spls_pkg::t_line              r_line, n_line;
    spls_pkg::t_kind              r_kind, n_kind;
    logic                         res_valid;

    assign o_advance = i_stage.valid && (!r_out_valid || o_report.ready);

    always_comb begin
        spls_pkg::t_prog np;
        spls_pkg::t_byte b;
        np        = '0;
        b         = i_stage.item.data_byte;
        n_prog    = r_prog;
        n_hit     = r_hit;
        n_eq      = r_eq;
        n_quote   = r_quote;
        n_bin     = r_bin;
        n_skip    = r_skip;
        n_count   = r_count;
        res_valid = 1'b0;
        n_line    = spls_pkg::t_line'(r_count);
        n_kind    = spls_pkg::KIND_WARN;

        if (o_advance) begin
            if (i_stage.item.first_of_file) begin
                n_prog  = '{default: '0};
                n_hit   = 1'b0;
                n_eq    = 1'b0;
                n_quote = 1'b0;
                n_bin   = 1'b0;
                n_skip  = 1'b0;
                n_count = COUNT_ONE;
            end
            if (!n_skip) begin
                if (b != spls_pkg::BYTE_LF) begin
                    for (int p = 0; p < spls_pkg::NUM_PAT; p++) begin
                        np = {n_prog[p][spls_pkg::MAX_LEN-2:0], 1'b1}
                             & spls_pkg::pat_mask(spls_pkg::t_pat_idx'(p), b);
                        n_prog[p] = np;
                        if (np[spls_pkg::PAT_LEN[p] - 4'd1]) begin
                            n_hit = 1'b1;
                        end
                    end
                    if (b == spls_pkg::BYTE_EQ) begin
                        n_eq = 1'b1;
                    end
                    if ((b == spls_pkg::BYTE_DQ) || (b == spls_pkg::BYTE_SQ)) begin
                        n_quote = 1'b1;
                    end
                    if ((b < spls_pkg::CTRL_LIMIT) && (b != spls_pkg::BYTE_CR)
                        && (b != spls_pkg::BYTE_TAB)) begin
                        n_bin = 1'b1;
                    end
                end
                if ((b == spls_pkg::BYTE_LF) || i_stage.item.last_of_file) begin
                    n_line = spls_pkg::t_line'(n_count);
                    if (n_bin) begin
                        res_valid = 1'b1;
                        n_kind    = spls_pkg::KIND_BINARY;
                        n_skip    = 1'b1;
                    end else begin
                        res_valid = n_hit || (n_eq && n_quote);
                        if (!(&n_count)) begin
                            n_count = n_count + COUNT_ONE;
                        end
                    end
                    n_prog  = '{default: '0};
                    n_hit   = 1'b0;
                    n_eq    = 1'b0;
                    n_quote = 1'b0;
                    n_bin   = 1'b0;
                end
            end
        end
    end

    assign n_out_valid = o_advance ? res_valid : (r_out_valid && !o_report.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog      <= '{default: '0};
            r_hit       <= 1'b0;
            r_eq        <= 1'b0;
            r_quote     <= 1'b0;
            r_bin       <= 1'b0;
            r_skip      <= 1'b0;
            r_count     <= COUNT_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_prog      <= n_prog;
            r_hit       <= n_hit;
            r_eq        <= n_eq;
            r_quote     <= n_quote;
            r_bin       <= n_bin;
            r_skip      <= n_skip;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && res_valid) begin
            r_line <= n_line;
            r_kind <= n_kind;
        end
    end

    assign o_report.valid       = r_out_valid;
    assign o_report.line_num    = r_line;
    assign o_report.report_kind = r_kind;

endmodule

`default_nettype wire

>>> hw/rtl/secret_pattern_line_scanner.sv
// ---------------------------------------------------------------------------
// Secret pattern line scanner
// Scans a byte stream of text files for lines that look like they hold keys.
// ---------------------------------------------------------------------------
// Usage:
// The byte channel i_byte carries one file byte per request, together with
// first_of_file (starts a new file: line count back to one, skip state and
// line state cleared) and last_of_file (the byte closes the current line).
// The report channel o_report carries at most one report per byte: the
// 1-based line number and a kind, a secret warning or a binary line, after
// which the rest of that file is ignored until the next first_of_file.
// An accepted byte waits in the input register until the scan stage takes
// it; its report, if any, is then loaded into the output register, which
// holds it visible until the receiver takes it. The scan stage takes no
// byte while a report in the output register is stalled.
// Throughput: one byte every cycle while no report is stalled, bounded by
// the update of the shift-and vectors and line flags held in the scan stage.
// Reset clears the input and output registers, all line state, and sets the
// line counter to one. When the receiver stalls, the report is held in the
// output register; one more byte may wait in the input register, after
// which ready falls until the report is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module secret_pattern_line_scanner #(
    parameter int unsigned LINE_COUNT_BITS = 20
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    spls_byte_if.sink      i_byte,
    spls_rep_if.source     o_report
);

    // Input register contents and the move from it into the scan stage.
    spls_pkg::t_stage stage;
    logic             advance;

    spls_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (advance),
        .o_stage   (stage)
    );

    // Scanning, line bookkeeping and the report register all live here.
    spls_scan #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .o_advance (advance),
        .o_report  (o_report)
    );

endmodule

`default_nettype wire

>>> hw/rtl/spls_chk.sv
// ---------------------------------------------------------------------------
// Secret pattern line scanner: port checker
// Watches the scanner's ports for handshake and reset behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

module spls_chk (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire spls_pkg::t_line i_out_line,
    input wire logic            i_out_kind
);

    // A pending report is not withdrawn while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("report withdrawn while stalled");

    // A stalled report keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_line) && $stable(i_out_kind)))
        else $error("report changed while stalled");

    // Reset empties the report register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("report pending after reset");

    // Reset empties the input register, so a byte can be taken at once.
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("byte channel not ready after reset");

endmodule

bind secret_pattern_line_scanner spls_chk u_spls_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_report.valid),
    .i_out_ready (o_report.ready),
    .i_out_line  (o_report.line_num),
    .i_out_kind  (o_report.report_kind)
);

`default_nettype wire
